>>> rtl/hsl_neighbor_edge_map_assert.svh
// Assertion macros shared by the checker of hsl_neighbor_edge_map.
`ifndef HSL_NEIGHBOR_EDGE_MAP_ASSERT_SVH
`define HSL_NEIGHBOR_EDGE_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HNEM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HNEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hnem_pkg.sv
package hnem_pkg;

  localparam int unsigned MaxColsDef   = 32;
  localparam int unsigned MaxRowsDef   = 1024;
  localparam int unsigned MaxColsLimit = 62;
  localparam int unsigned ColLimW      = 6;
  localparam int unsigned RowLimW      = 16;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ThrW     = 18;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned WidthW   = 6;
  localparam int unsigned ColOutW  = 5;
  localparam int unsigned RowOutW  = 10;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned ProdW    = ChanW + WeightW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned NbCount  = 4;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [ChanW-1:0]   ChanMax     = 8'd255;
  localparam logic [ChanW-1:0]   HueHalf     = ChanMax / 2;
  localparam logic [ThrW-1:0]    ThrReset    = 18'd10;
  localparam logic [WeightW-1:0] WeightReset = 16'd256;
  localparam logic [WidthW-1:0]  WidthReset  = 6'd32;

  typedef enum logic [IdxW-1:0] {
    REG_EDGE_THRESHOLD    = 3'd0,
    REG_HUE_WEIGHT        = 3'd1,
    REG_SATURATION_WEIGHT = 3'd2,
    REG_LIGHTNESS_WEIGHT  = 3'd3,
    REG_FRAME_WIDTH       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] light;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] hue;
  } color_t;

  typedef struct packed {
    logic [ChanW-1:0] pix_hue;
    logic [ChanW-1:0] pix_sat;
    logic [ChanW-1:0] pix_light;
    logic             frame_end;
  } pix_t;

  typedef struct packed {
    logic               edge_flag;
    logic [ColOutW-1:0] out_col;
    logic [RowOutW-1:0] out_row;
    logic               run_last;
    logic               frame_done;
  } res_t;

  typedef struct packed {
    logic [IdxW-1:0]     cfg_index;
    logic [CfgDataW-1:0] cfg_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [ThrW-1:0]    edge_threshold;
    logic [WeightW-1:0] hue_weight;
    logic [WeightW-1:0] saturation_weight;
    logic [WeightW-1:0] lightness_weight;
    logic [WidthW-1:0]  frame_width;
  } cfg_t;

  // One pixel's worth of flags to report: an optional run from the row above, then an
  // optional run of the current row starting at column zero.
  typedef struct packed {
    logic [MaxColsLimit-1:0] prev_flags;
    logic [MaxColsLimit-1:0] curr_flags;
    logic                    has_prev;
    logic                    has_curr;
    logic [ColLimW-1:0]      p_start;
    logic [ColLimW-1:0]      p_end;
    logic [ColLimW-1:0]      c_end;
    logic [RowLimW-1:0]      prow;
    logic [RowLimW-1:0]      row;
  } job_t;

endpackage

>>> rtl/hnem_stream_if.sv
interface hnem_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hnem_queue.sv
module hnem_queue import hnem_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  job_t            job_i,
  input  logic            pop_i,
  output job_t            head_o,
  output logic [CntW-1:0] count_o
);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;
endmodule

>>> rtl/hnem_front.sv
module hnem_front import hnem_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDef,
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hnem_stream_if.sink     pix_i,
  input  cfg_t            cfg_i,
  input  logic [CntW-1:0] q_count_i,
  output logic            push_o,
  output job_t            job_o
);
  localparam int unsigned ColW = $clog2(MAX_COLS);
  localparam int unsigned RowW = $clog2(MAX_ROWS);
  localparam logic [ColW-1:0] LastCol = ColW'(MAX_COLS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(MAX_ROWS - 1);
  localparam int unsigned NbLeft    = 0;
  localparam int unsigned NbUp      = 1;
  localparam int unsigned NbUpLeft  = 2;
  localparam int unsigned NbUpRight = 3;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [ColW-1:0] col_m1;
    logic [ColW-1:0] col_p1;
    logic            row_end;
    logic            frame_end;
    logic            above;
    logic            has_left;
    logic            has_right;
    logic [RowW-1:0] row;
    logic [RowW-1:0] prow;
  } ctrl_t;

  typedef struct packed {
    logic [ProdW-1:0] hue;
    logic [ProdW-1:0] sat;
    logic [ProdW-1:0] light;
  } prod_t;

  function automatic logic [ChanW-1:0] chan_dist(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [ChanW-1:0] hue_dist(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = chan_dist(a, b);
    return (d > HueHalf) ? ChanMax - d : d;
  endfunction

  color_t          line_mem [MAX_COLS];
  color_t          up_rd_q;
  color_t          ur_rd_q;
  color_t          left_q;
  color_t          upleft_q;
  color_t          cur_q;
  color_t          nb_left_q;
  ctrl_t           s1_q;
  ctrl_t           s2_q;
  prod_t           prod_q [NbCount];
  prod_t           prod_d [NbCount];
  logic            s1_v_q;
  logic            s2_v_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            above_q;
  logic [MAX_COLS-1:0] prev_q;
  logic [MAX_COLS-1:0] curr_q;

  color_t          cur;
  logic            accept;
  logic [ColW-1:0] wm1;
  logic [ColW-1:0] col;
  logic [ColW-1:0] col_nx;
  logic            row_end;
  ctrl_t           s1_d;
  color_t          nb [NbCount];
  logic [SumW-1:0] sum [NbCount];
  logic [NbCount-1:0] hit;
  logic            hit_left;
  logic            hit_up;
  logic            hit_ul;
  logic            hit_ur;
  logic [MAX_COLS-1:0] prev_upd;
  logic [MAX_COLS-1:0] curr_upd;
  logic [MAX_COLS-1:0] prev_d;
  logic [MAX_COLS-1:0] curr_d;
  logic            has_prev;

  assign cur    = '{light: pix_i.data.pix_light, sat: pix_i.data.pix_sat,
                    hue: pix_i.data.pix_hue};
  assign accept = pix_i.valid && pix_i.ready;

  assign pix_i.ready = (q_count_i + CntW'(s1_v_q) + CntW'(s2_v_q)) < CntW'(QueueDepth);

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      wm1 = '0;
    end else if (7'(cfg_i.frame_width) > 7'(MAX_COLS)) begin
      wm1 = LastCol;
    end else begin
      wm1 = ColW'(cfg_i.frame_width - WidthW'(1));
    end
    col     = (col_q > wm1) ? wm1 : col_q;
    col_nx  = (col == LastCol) ? col : col + ColW'(1);
    row_end = (col == wm1) || pix_i.data.frame_end;
    s1_d = '{col: col, col_m1: col - ColW'(1), col_p1: col_nx, row_end: row_end,
             frame_end: pix_i.data.frame_end, above: above_q, has_left: col != '0,
             has_right: col < wm1, row: row_q,
             prow: (row_q == '0) ? LastRow : row_q - RowW'(1)};
  end

  always_comb begin
    nb[NbLeft]    = nb_left_q;
    nb[NbUp]      = up_rd_q;
    nb[NbUpLeft]  = upleft_q;
    nb[NbUpRight] = ur_rd_q;
    for (int n = 0; n < NbCount; n++) begin
      prod_d[n].hue   = ProdW'(hue_dist(cur_q.hue, nb[n].hue)) * ProdW'(cfg_i.hue_weight);
      prod_d[n].sat   = ProdW'(chan_dist(cur_q.sat, nb[n].sat)) *
                        ProdW'(cfg_i.saturation_weight);
      prod_d[n].light = ProdW'(chan_dist(cur_q.light, nb[n].light)) *
                        ProdW'(cfg_i.lightness_weight);
    end
  end

  always_comb begin
    for (int n = 0; n < NbCount; n++) begin
      sum[n] = SumW'(prod_q[n].hue) + SumW'(prod_q[n].sat) + SumW'(prod_q[n].light);
      hit[n] = sum[n][SumW-1 -: ThrW] > cfg_i.edge_threshold;
    end
    hit_left = hit[NbLeft] && s2_q.has_left;
    hit_up   = hit[NbUp] && s2_q.above;
    hit_ul   = hit[NbUpLeft] && s2_q.above && s2_q.has_left;
    hit_ur   = hit[NbUpRight] && s2_q.above && s2_q.has_right;

    prev_upd = prev_q;
    curr_upd = curr_q;
    if (hit_left) begin
      curr_upd[s2_q.col]    = 1'b1;
      curr_upd[s2_q.col_m1] = 1'b1;
    end
    if (hit_up) begin
      curr_upd[s2_q.col] = 1'b1;
      prev_upd[s2_q.col] = 1'b1;
    end
    if (hit_ul) begin
      curr_upd[s2_q.col]    = 1'b1;
      prev_upd[s2_q.col_m1] = 1'b1;
    end
    if (hit_ur) begin
      curr_upd[s2_q.col]    = 1'b1;
      prev_upd[s2_q.col_p1] = 1'b1;
    end

    if (s2_q.frame_end) begin
      prev_d = '0;
      curr_d = '0;
    end else if (s2_q.row_end) begin
      prev_d = curr_upd;
      curr_d = '0;
    end else begin
      prev_d = prev_upd;
      curr_d = curr_upd;
    end

    has_prev = s2_q.above && (s2_q.has_left || s2_q.row_end);
    job_o = '{prev_flags: MaxColsLimit'(prev_upd), curr_flags: MaxColsLimit'(curr_upd),
              has_prev: has_prev, has_curr: s2_q.frame_end,
              p_start: ColLimW'(s2_q.has_left ? s2_q.col_m1 : s2_q.col),
              p_end: ColLimW'(s2_q.row_end ? wm1 : s2_q.col_m1),
              c_end: ColLimW'(s2_q.col), prow: RowLimW'(s2_q.prow),
              row: RowLimW'(s2_q.row)};
    push_o = s2_v_q && (has_prev || s2_q.frame_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      above_q <= 1'b0;
      prev_q  <= '0;
      curr_q  <= '0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      if (accept) begin
        if (pix_i.data.frame_end) begin
          col_q   <= '0;
          row_q   <= '0;
          above_q <= 1'b0;
        end else if (row_end) begin
          col_q   <= '0;
          row_q   <= (row_q == LastRow) ? '0 : row_q + RowW'(1);
          above_q <= 1'b1;
        end else begin
          col_q <= col + ColW'(1);
        end
      end
      if (s2_v_q) begin
        prev_q <= prev_d;
        curr_q <= curr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col] <= cur;
      up_rd_q       <= line_mem[col];
      ur_rd_q       <= line_mem[col_nx];
      nb_left_q     <= left_q;
      left_q        <= cur;
      cur_q         <= cur;
      s1_q          <= s1_d;
    end
    if (s1_v_q) begin
      upleft_q <= up_rd_q;
      s2_q     <= s1_q;
      for (int n = 0; n < NbCount; n++) begin
        prod_q[n] <= prod_d[n];
      end
    end
  end
endmodule

>>> rtl/hnem_back.sv
module hnem_back import hnem_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  job_t            head_i,
  input  logic [CntW-1:0] q_count_i,
  output logic            pop_o,
  hnem_stream_if.source   res_o
);
  localparam int unsigned ColW = $clog2(MAX_COLS);

  typedef enum logic {
    SEG_PREV,
    SEG_CURR
  } seg_e;

  logic            active_q;
  seg_e            seg_q;
  logic [ColW-1:0] k_q;
  logic            out_v_q;
  res_t            out_q;

  seg_e            seg;
  logic [ColW-1:0] k;
  logic [ColW-1:0] seg_end;
  logic [MAX_COLS-1:0] prev_flags;
  logic [MAX_COLS-1:0] curr_flags;
  logic            seg_last;
  logic            job_last;
  logic            load;

  always_comb begin
    prev_flags = head_i.prev_flags[MAX_COLS-1:0];
    curr_flags = head_i.curr_flags[MAX_COLS-1:0];
    if (active_q) begin
      seg = seg_q;
      k   = k_q;
    end else if (head_i.has_prev) begin
      seg = SEG_PREV;
      k   = ColW'(head_i.p_start);
    end else begin
      seg = SEG_CURR;
      k   = '0;
    end
    seg_end  = (seg == SEG_PREV) ? ColW'(head_i.p_end) : ColW'(head_i.c_end);
    seg_last = (k == seg_end);
    job_last = seg_last && ((seg == SEG_CURR) || !head_i.has_curr);
    load     = (q_count_i != '0) && (!out_v_q || res_o.ready);
  end

  assign pop_o = load && job_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      seg_q    <= SEG_PREV;
      k_q      <= '0;
      out_v_q  <= 1'b0;
      out_q    <= '0;
    end else begin
      if (load) begin
        out_v_q          <= 1'b1;
        out_q.edge_flag  <= (seg == SEG_PREV) ? prev_flags[k] : curr_flags[k];
        out_q.out_col    <= ColOutW'(k);
        out_q.out_row    <= RowOutW'((seg == SEG_PREV) ? head_i.prow : head_i.row);
        out_q.run_last   <= job_last;
        out_q.frame_done <= job_last && head_i.has_curr;
        if (job_last) begin
          active_q <= 1'b0;
        end else if (seg_last) begin
          active_q <= 1'b1;
          seg_q    <= SEG_CURR;
          k_q      <= '0;
        end else begin
          active_q <= 1'b1;
          seg_q    <= seg;
          k_q      <= k + ColW'(1);
        end
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;
endmodule

>>> rtl/hsl_neighbor_edge_map.sv
// Marks edges in an HSL pixel stream delivered in raster order. A pixel is flagged when
// any in-frame neighbor of its 3x3 window differs from it by more than edge_threshold,
// where the difference is the weighted sum of the circular hue distance and the
// saturation and lightness distances, with 8.8 weights and the sum truncated once.
// Flags come out one row and one column behind the input, each with its row and column,
// and the pixel that carries frame_end flushes every pending flag of the frame. One pixel
// is accepted per cycle while the input is not stalled; the four neighbor compares run
// in parallel over a three-stage front pipeline (line buffer read, multiply, sum and
// compare). Flags leave the result port at one per cycle while it is ready, so a pixel
// that ends a row or the frame holds the port until all its flags are out, and the input
// stalls once the pixels in the compare pipeline and the jobs in the four-entry queue
// before the flag sequencer add up to four. Flags are offered from a registered output.
// Registers may be written only while the block is idle.
module hsl_neighbor_edge_map import hnem_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDef,
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hnem_stream_if.sink   pix_i,
  hnem_stream_if.sink   cfg_i,
  hnem_stream_if.source res_o
);
  cfg_t            cfg_q;
  logic            push;
  logic            pop;
  job_t            job;
  job_t            head;
  logic [CntW-1:0] q_count;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_threshold    <= ThrReset;
      cfg_q.hue_weight        <= WeightReset;
      cfg_q.saturation_weight <= WeightReset;
      cfg_q.lightness_weight  <= WeightReset;
      cfg_q.frame_width       <= WidthReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.data.cfg_index))
        REG_EDGE_THRESHOLD: begin
          cfg_q.edge_threshold <= cfg_i.data.cfg_data[ThrW-1:0];
        end
        REG_HUE_WEIGHT: begin
          cfg_q.hue_weight <= cfg_i.data.cfg_data[WeightW-1:0];
        end
        REG_SATURATION_WEIGHT: begin
          cfg_q.saturation_weight <= cfg_i.data.cfg_data[WeightW-1:0];
        end
        REG_LIGHTNESS_WEIGHT: begin
          cfg_q.lightness_weight <= cfg_i.data.cfg_data[WeightW-1:0];
        end
        REG_FRAME_WIDTH: begin
          cfg_q.frame_width <= cfg_i.data.cfg_data[WidthW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hnem_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .cfg_i     (cfg_q),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (job)
  );

  hnem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  hnem_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_count_i (q_count),
    .pop_o     (pop),
    .res_o     (res_o)
  );
endmodule

>>> rtl/hnem_checker.sv
`include "hsl_neighbor_edge_map_assert.svh"

module hnem_checker import hnem_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_data_i
);
  logic xfer;
  logic more;

  assign xfer = res_valid_i && res_ready_i;
  assign more = xfer && !res_data_i.run_last;

  // A stalled result stays offered unchanged.
  `HNEM_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i), "result changed while stalled")

  // The flags of one pixel follow each other without a gap.
  `HNEM_ASSERT_NEXT(a_run_gapless, clk_i, rst_ni, more, res_valid_i, "gap inside the flags of one pixel")

  // Within one pixel's flags the column steps by one or restarts at zero.
  `HNEM_ASSERT_NEXT(a_run_cols, clk_i, rst_ni, more, (res_data_i.out_col == 5'($past(res_data_i.out_col) + 5'd1)) || (res_data_i.out_col == '0), "column order broken")

  // The first flag after a frame ends belongs to row zero of the next frame.
  `HNEM_ASSERT_SAME(a_new_frame_row, clk_i, rst_ni, res_valid_i && $past(xfer && res_data_i.frame_done), res_data_i.out_row == '0, "new frame does not start at row zero")
endmodule

bind hsl_neighbor_edge_map hnem_checker u_hnem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

>>> tb/hsl_neighbor_edge_map_tb.sv
module hsl_neighbor_edge_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hnem_pkg::*;

  localparam int unsigned MaxCols      = MaxColsDef;
  localparam int unsigned MaxRows      = MaxRowsDef;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned HoldCycles   = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hnem_stream_if #(.payload_t(pix_t))    pix_if ();
  hnem_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();
  hnem_stream_if #(.payload_t(res_t))    res_if ();

  hsl_neighbor_edge_map dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  res_t        expected_flags[$];
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;

  logic [ThrW-1:0]    thr_shadow     = ThrReset;
  logic [WeightW-1:0] hue_w_shadow   = WeightReset;
  logic [WeightW-1:0] sat_w_shadow   = WeightReset;
  logic [WeightW-1:0] light_w_shadow = WeightReset;
  logic [WidthW-1:0]  width_shadow   = WidthReset;

  color_t             line_store[MaxCols];
  logic [MaxCols-1:0] prev_marks = '0;
  logic [MaxCols-1:0] curr_marks = '0;
  color_t             left_px    = '0;
  color_t             upleft_px  = '0;
  int unsigned        col_pos    = 0;
  int unsigned        row_pos    = 0;
  bit                 row_above  = 1'b0;
  color_t             walk_px    = '0;

  always #1ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // A long hold-off takes precedence over the random ready pattern.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic string flag_text(res_t r);
    return $sformatf("edge=%0b col=%0d row=%0d last=%0b done=%0b",
                     r.edge_flag, r.out_col, r.out_row, r.run_last, r.frame_done);
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void check_flag(res_t got);
    res_t want;
    if (expected_flags.size() == 0) begin
      report_error({"unexpected transfer ", flag_text(got)});
    end else begin
      want = expected_flags.pop_front();
      if (got.edge_flag !== want.edge_flag || got.out_col !== want.out_col ||
          got.out_row !== want.out_row || got.run_last !== want.run_last ||
          got.frame_done !== want.frame_done) begin
        report_error($sformatf("expected %s, got %s", flag_text(want), flag_text(got)));
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      check_flag(res_if.data);
    end
  end

  function automatic bit colors_differ(color_t a, color_t b);
    int unsigned     dh;
    int unsigned     ds;
    int unsigned     dl;
    longint unsigned total;
    dh = (a.hue > b.hue) ? a.hue - b.hue : b.hue - a.hue;
    ds = (a.sat > b.sat) ? a.sat - b.sat : b.sat - a.sat;
    dl = (a.light > b.light) ? a.light - b.light : b.light - a.light;
    if (dh > HueHalf) dh = ChanMax - dh;
    total = 64'(ds) * 64'(sat_w_shadow) + 64'(dh) * 64'(hue_w_shadow) +
            64'(dl) * 64'(light_w_shadow);
    return (total >> 8) > 64'(thr_shadow);
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_shadow;
    if (w < 1) w = 1;
    if (w > MaxCols) w = MaxCols;
    return w;
  endfunction

  function automatic res_t make_flag(bit mark, int unsigned col, int unsigned row);
    res_t f;
    f.edge_flag  = mark;
    f.out_col    = col[ColOutW-1:0];
    f.out_row    = row[RowOutW-1:0];
    f.run_last   = 1'b0;
    f.frame_done = 1'b0;
    return f;
  endfunction

  function automatic void predict_edge_flags(pix_t p);
    color_t      cur;
    color_t      up;
    int unsigned w;
    int unsigned c;
    int unsigned r;
    int unsigned prow;
    int unsigned first;
    int unsigned k;
    bit          rowend;
    res_t        tail;
    w = active_width();
    c = col_pos;
    if (c > w - 1) c = w - 1;
    r = row_pos;
    prow = (r + MaxRows - 1) % MaxRows;
    cur.hue   = p.pix_hue;
    cur.sat   = p.pix_sat;
    cur.light = p.pix_light;
    up = '0;
    first = expected_flags.size();

    if (c >= 1 && colors_differ(cur, left_px)) begin
      curr_marks[c]     = 1'b1;
      curr_marks[c - 1] = 1'b1;
    end
    if (row_above) begin
      up = line_store[c];
      if (colors_differ(cur, up)) begin
        curr_marks[c] = 1'b1;
        prev_marks[c] = 1'b1;
      end
      if (c >= 1 && colors_differ(cur, upleft_px)) begin
        curr_marks[c]     = 1'b1;
        prev_marks[c - 1] = 1'b1;
      end
      if (c + 1 < w && colors_differ(cur, line_store[c + 1])) begin
        curr_marks[c]     = 1'b1;
        prev_marks[c + 1] = 1'b1;
      end
    end
    upleft_px     = up;
    left_px       = cur;
    line_store[c] = cur;

    rowend = (c == w - 1) || p.frame_end;
    if (row_above) begin
      if (c >= 1) expected_flags.push_back(make_flag(prev_marks[c - 1], c - 1, prow));
      if (rowend) begin
        for (k = c; k < w; k++) expected_flags.push_back(make_flag(prev_marks[k], k, prow));
      end
    end
    if (p.frame_end) begin
      for (k = 0; k <= c; k++) expected_flags.push_back(make_flag(curr_marks[k], k, r));
    end
    if (expected_flags.size() > first) begin
      tail = expected_flags.pop_back();
      tail.run_last   = 1'b1;
      tail.frame_done = p.frame_end;
      expected_flags.push_back(tail);
    end

    if (p.frame_end) begin
      prev_marks = '0;
      curr_marks = '0;
      col_pos    = 0;
      row_pos    = 0;
      row_above  = 1'b0;
    end else if (rowend) begin
      prev_marks = curr_marks;
      curr_marks = '0;
      col_pos    = 0;
      row_pos    = (r + 1) % MaxRows;
      row_above  = 1'b1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic pix_t make_pix(int unsigned h, int unsigned s, int unsigned l,
                                    bit last);
    pix_t p;
    p.pix_hue   = h[ChanW-1:0];
    p.pix_sat   = s[ChanW-1:0];
    p.pix_light = l[ChanW-1:0];
    p.frame_end = last;
    return p;
  endfunction

  // Mostly a slow random walk so that neighbors are close, with occasional jumps.
  function automatic pix_t random_pixel(bit last);
    if ($urandom_range(5) == 0) begin
      walk_px = 24'($urandom);
    end else begin
      walk_px.hue   = walk_px.hue + 8'($urandom_range(6)) - 8'd3;
      walk_px.sat   = walk_px.sat + 8'($urandom_range(6)) - 8'd3;
      walk_px.light = walk_px.light + 8'($urandom_range(6)) - 8'd3;
    end
    return make_pix(walk_px.hue, walk_px.sat, walk_px.light, last);
  endfunction

  function automatic int unsigned pick_weight();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(16'hFFFF);
      default: return $urandom_range(128, 512);
    endcase
  endfunction

  task automatic send_pixel(pix_t p);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_edge_flags(p);
    @(negedge clk_i);
  endtask

  task automatic wait_for_idle();
    pix_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (expected_flags.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_wr_t wr;
    wr.cfg_index = idx;
    wr.cfg_data  = value[CfgDataW-1:0];
    pix_if.valid <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_EDGE_THRESHOLD:    thr_shadow     = value[ThrW-1:0];
      REG_HUE_WEIGHT:        hue_w_shadow   = value[WeightW-1:0];
      REG_SATURATION_WEIGHT: sat_w_shadow   = value[WeightW-1:0];
      REG_LIGHTNESS_WEIGHT:  light_w_shadow = value[WeightW-1:0];
      REG_FRAME_WIDTH:       width_shadow   = value[WidthW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned thr, int unsigned hue_w, int unsigned sat_w,
                            int unsigned light_w, int unsigned width);
    wait_for_idle();
    write_reg(REG_EDGE_THRESHOLD, thr);
    write_reg(REG_HUE_WEIGHT, hue_w);
    write_reg(REG_SATURATION_WEIGHT, sat_w);
    write_reg(REG_LIGHTNESS_WEIGHT, light_w);
    write_reg(REG_FRAME_WIDTH, width);
  endtask

  task automatic set_width(int unsigned width);
    wait_for_idle();
    write_reg(REG_FRAME_WIDTH, width);
  endtask

  task automatic send_frame(int unsigned rows, bit cut_short, output int unsigned count);
    int unsigned w;
    int unsigned total;
    w = active_width();
    total = rows * w;
    if (cut_short && w > 1) total -= $urandom_range(1, w - 1);
    for (int unsigned i = 0; i < total; i++) send_pixel(random_pixel(i == total - 1));
    count = total;
  endtask

  task automatic randomize_config();
    int unsigned thr;
    int unsigned width;
    case ($urandom_range(4))
      0:       thr = 0;
      1:       thr = 18'h3FFFF;
      2:       thr = $urandom_range(1, 40);
      3:       thr = $urandom_range(18'h3FFFF);
      default: thr = ThrReset;
    endcase
    case ($urandom_range(9))
      0:       width = 0;
      1:       width = $urandom_range(MaxCols + 1, 63);
      2:       width = MaxCols;
      default: width = $urandom_range(1, 8);
    endcase
    set_config(thr, pick_weight(), pick_weight(), pick_weight(), width);
  endtask

  task automatic test_single_pixel();
    send_pixel(make_pix(255, 255, 255, 1'b1));
  endtask

  // Hue pairs hit the circular fold on both sides of half a turn.
  task automatic test_channel_extremes();
    set_config(ThrReset, WeightReset, WeightReset, WeightReset, 3);
    send_pixel(make_pix(0, 0, 0, 1'b0));
    send_pixel(make_pix(255, 0, 0, 1'b0));
    send_pixel(make_pix(128, 0, 0, 1'b0));
    send_pixel(make_pix(127, 0, 0, 1'b0));
    send_pixel(make_pix(0, 255, 0, 1'b0));
    send_pixel(make_pix(0, 0, 255, 1'b0));
    send_pixel(make_pix(129, 255, 255, 1'b0));
    send_pixel(make_pix(255, 255, 255, 1'b0));
    send_pixel(make_pix(0, 255, 255, 1'b1));
  endtask

  task automatic test_weight_extremes();
    set_config(18'h3FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
    send_pixel(make_pix(0, 0, 0, 1'b0));
    send_pixel(make_pix(128, 255, 255, 1'b0));
    send_pixel(make_pix(255, 255, 0, 1'b0));
    send_pixel(make_pix(127, 0, 255, 1'b1));
    set_config(0, 0, 16'hFFFF, 1, 2);
    send_pixel(make_pix(0, 0, 0, 1'b0));
    send_pixel(make_pix(200, 0, 1, 1'b0));
    send_pixel(make_pix(0, 1, 0, 1'b0));
    send_pixel(make_pix(255, 255, 255, 1'b1));
  endtask

  task automatic test_width_clamp_and_short_rows();
    set_config(ThrReset, WeightReset, WeightReset, WeightReset, 0);
    send_pixel(random_pixel(1'b0));
    send_pixel(random_pixel(1'b1));
    set_width(63);
    send_pixel(random_pixel(1'b0));
    send_pixel(random_pixel(1'b0));
    send_pixel(random_pixel(1'b1));
    set_width(4);
    for (int unsigned i = 0; i < 6; i++) send_pixel(random_pixel(i == 5));
  endtask

  // Widens and then narrows the frame in the middle of a row.
  task automatic test_width_change();
    set_config(ThrReset, WeightReset, WeightReset, WeightReset, 4);
    for (int unsigned i = 0; i < 6; i++) send_pixel(random_pixel(1'b0));
    set_width(8);
    for (int unsigned i = 0; i < 4; i++) send_pixel(random_pixel(1'b0));
    set_width(2);
    for (int unsigned i = 0; i < 3; i++) send_pixel(random_pixel(i == 2));
  endtask

  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(ThrReset, WeightReset, WeightReset, WeightReset, MaxCols);
    hold_left = HoldCycles;
    for (int unsigned i = 0; i < 2 * MaxCols; i++) send_pixel(random_pixel(i == 2 * MaxCols - 1));
    wait_for_idle();
  endtask

  // The optional wide frame first writes every line store entry, so that later
  // mid-frame widening never reads an entry that was never written.
  task automatic test_random_traffic(int unsigned budget, int unsigned s_pct,
                                     int unsigned r_pct, bit wide_first);
    int unsigned sent;
    int unsigned n;
    int unsigned rows;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    if (wide_first) begin
      set_config(ThrReset, WeightReset, WeightReset, WeightReset, MaxCols);
      send_frame(2, 1'b0, n);
      sent += n;
    end
    while (sent < budget) begin
      if ($urandom_range(2) == 0) randomize_config();
      rows = (active_width() > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      send_frame(rows, $urandom_range(3) == 0, n);
      sent += n;
    end
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    foreach (line_store[i]) line_store[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_pixel();
    test_channel_extremes();
    test_weight_extremes();
    test_width_clamp_and_short_rows();
    test_random_traffic(80, 37, 69, 1'b1);
    test_width_change();
    test_result_backpressure();
    test_random_traffic(50, 69, 37, 1'b0);
    test_random_traffic(50, 0, 0, 1'b0);

    wait_for_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
